// ----- hdl/qou_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// qou_pkg
// Constants and types shared by the quaternion orientation unit.
// ----------------------------------------------------------------------------
package qou_pkg;

    localparam int ATAN_STEPS = 24;

    localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;

    localparam logic signed [15:0] RESET_W = 16'sd13985;
    localparam logic signed [15:0] RESET_X = 16'sd5793;
    localparam logic signed [15:0] RESET_Y = 16'sd2399;
    localparam logic signed [15:0] RESET_Z = 16'sd5793;

    localparam logic signed [35:0] ONE_Q28 = 36'sd268435456;

    localparam logic OP_EULER = 1'b0;
    localparam logic OP_MULT  = 1'b1;

    typedef logic signed [15:0] q14_t;

    // Arctangent step table, 32-bit angle scale with pi = 2^31.
    function automatic logic signed [31:0] atan_step(input logic [4:0] idx);
        logic signed [31:0] v;
        begin
            unique case (idx)
                5'd0:    v = 32'sd536870912;
                5'd1:    v = 32'sd316933406;
                5'd2:    v = 32'sd167458907;
                5'd3:    v = 32'sd85004756;
                5'd4:    v = 32'sd42667331;
                5'd5:    v = 32'sd21354465;
                5'd6:    v = 32'sd10679838;
                5'd7:    v = 32'sd5340245;
                5'd8:    v = 32'sd2670163;
                5'd9:    v = 32'sd1335087;
                5'd10:   v = 32'sd667544;
                5'd11:   v = 32'sd333772;
                5'd12:   v = 32'sd166886;
                5'd13:   v = 32'sd83443;
                5'd14:   v = 32'sd41722;
                5'd15:   v = 32'sd20861;
                5'd16:   v = 32'sd10430;
                5'd17:   v = 32'sd5215;
                5'd18:   v = 32'sd2608;
                5'd19:   v = 32'sd1304;
                5'd20:   v = 32'sd652;
                5'd21:   v = 32'sd326;
                5'd22:   v = 32'sd163;
                5'd23:   v = 32'sd81;
                default: v = 32'sd0;
            endcase
            return v;
        end
    endfunction

    // Round at bit 14 (floor after adding half) and clamp to 16 bits.
    function automatic q14_t round_sat(input logic signed [39:0] v);
        logic signed [39:0] r;
        begin
            r = (v + 40'sd8192) >>> 14;
            if (r > 40'sd32767)
                return 16'sh7FFF;
            else if (r < -40'sd32768)
                return 16'sh8000;
            else
                return r[15:0];
        end
    endfunction

    function automatic q14_t sat16(input logic signed [19:0] v);
        begin
            if (v > 20'sd32767)
                return 16'sh7FFF;
            else if (v < -20'sd32768)
                return 16'sh8000;
            else
                return v[15:0];
        end
    endfunction

endpackage

`default_nettype wire

// ----- hdl/qou_cordic.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// qou_cordic
// Rotation-mode CORDIC, one micro-rotation per cycle, half-angle sin/cos.
// ----------------------------------------------------------------------------
module qou_cordic #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               start,
    input  wire signed [15:0] angle,
    output logic              done,
    output qou_pkg::q14_t     cos_out,
    output qou_pkg::q14_t     sin_out
);
    import qou_pkg::*;

    localparam int NSTEP = (CORDIC_ITERATIONS > ATAN_STEPS) ? ATAN_STEPS
                                                            : CORDIC_ITERATIONS;

    logic signed [31:0] x_reg, x_next;
    logic signed [31:0] y_reg, y_next;
    logic signed [32:0] z_reg, z_next;
    logic [4:0]         step_reg, step_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic signed [31:0] dx, dy;
    logic signed [32:0] at;

    always_comb
    begin
        dx        = y_reg >>> step_reg;
        dy        = x_reg >>> step_reg;
        at        = 33'(atan_step(step_reg));
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            x_next    = CORDIC_GAIN_Q30;
            y_next    = 32'sd0;
            z_next    = {{2{angle[15]}}, angle, 15'd0};
            step_next = 5'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!z_reg[32])
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - at;
            end
            else
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + at;
            end
            step_next = step_reg + 5'd1;
            if (step_reg == 5'(NSTEP - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    logic signed [19:0] xr, yr;
    always_comb
    begin
        xr = 20'((48'(x_reg) + 48'sd32768) >>> 16);
        yr = 20'((48'(y_reg) + 48'sd32768) >>> 16);
    end

    assign done    = done_reg;
    assign cos_out = sat16(xr);
    assign sin_out = sat16(yr);

endmodule

`default_nettype wire

// ----- hdl/quaternion_orientation_unit_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_orientation_unit_top
// Orientation quaternion keeper with Euler load, Hamilton product and
// rotation-matrix output.
// ----------------------------------------------------------------------------
// One item at a time. An Euler load (opcode 0) runs three CORDIC passes (one
// per angle) on a single shared CORDIC, each with start, micro-rotations
// capped at 24 and done, then products on the shared 16x16 multiplier. A
// quaternion multiply (opcode 1) runs its products on the multiplier; its new
// components are held aside and written to the state together at the end.
// Both end with the matrix step (nine products, one register stage,
// assembly), then three row items leave, one per accepted output cycle.
// in_ready is high only while the sequencer is idle.
// The shared multiplier is the only multiplier in the design. Euler
// products are rounded into registers, Hamilton products are accumulated
// into a 36-bit sum and matrix products land in a register.
// ----------------------------------------------------------------------------
module quaternion_orientation_unit_top #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               in_valid,
    output logic              in_ready,
    input  wire               opcode,
    input  wire signed [15:0] roll,
    input  wire signed [15:0] pitch,
    input  wire signed [15:0] yaw,
    input  wire signed [15:0] factor_w,
    input  wire signed [15:0] factor_x,
    input  wire signed [15:0] factor_y,
    input  wire signed [15:0] factor_z,
    output logic              out_valid,
    input  wire               out_ready,
    output qou_pkg::q14_t     quat_w,
    output qou_pkg::q14_t     quat_x,
    output qou_pkg::q14_t     quat_y,
    output qou_pkg::q14_t     quat_z,
    output logic [1:0]        row_index,
    output qou_pkg::q14_t     row_entry_first,
    output qou_pkg::q14_t     row_entry_second,
    output qou_pkg::q14_t     row_entry_third,
    output logic              last_row
);
    import qou_pkg::*;

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CORD  = 3'd1;  // waiting on a CORDIC pass
    localparam logic [2:0] S_EUL   = 3'd2;  // Euler products
    localparam logic [2:0] S_HAM   = 3'd3;  // Hamilton products
    localparam logic [2:0] S_MAT   = 3'd4;  // matrix products
    localparam logic [2:0] S_OUT   = 3'd5;  // emit rows

    logic [2:0] state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [1:0] ang_reg, ang_next;   // which angle is in the CORDIC
    logic [1:0] row_reg, row_next;

    // Captured item
    q14_t       ang_r_reg, ang_p_reg, ang_y_reg;
    q14_t       fw_reg, fx_reg, fy_reg, fz_reg;

    // Quaternion state
    q14_t       qw_reg, qx_reg, qy_reg, qz_reg;
    // Hamilton components held until all four are done
    q14_t       hx_reg, hy_reg, hz_reg;

    // sin/cos of the three half angles
    q14_t       cr_reg, sr_reg, cp_reg, sp_reg, cy_reg, sy_reg;
    // Euler intermediates
    q14_t       t0_reg, t1_reg;
    logic signed [19:0] e_reg;      // one rounded product, combined with the next

    // Hamilton sum, kept in Q7.28 before rounding
    logic signed [35:0] acc_reg;
    q14_t       m_reg [9];

    // Shared multiplier
    q14_t               ma, mb;
    logic signed [31:0] prod;
    q14_t               pr;          // rounded product (mul14)

    assign prod = ma * mb;
    always_comb
    begin
        logic signed [31:0] rr;
        rr = (prod + 32'sd8192) >>> 14;
        pr = rr[15:0];
    end

    // CORDIC
    logic               cord_start;
    logic               cord_done;
    q14_t               cord_cos, cord_sin;
    logic signed [15:0] cord_angle;

    qou_cordic #(
        .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
    ) u_cordic (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cord_start),
        .angle  (cord_angle),
        .done   (cord_done),
        .cos_out(cord_cos),
        .sin_out(cord_sin)
    );

    always_comb
    begin
        unique case (ang_reg)
            2'd0:    cord_angle = ang_r_reg;
            2'd1:    cord_angle = ang_p_reg;
            default: cord_angle = ang_y_reg;
        endcase
    end

    wire in_fire  = in_valid && in_ready;
    wire out_fire = out_valid && out_ready;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    // Operand selection for the multiplier, by state and step.
    // Euler schedule (mul14 each):
    //  0 cp*cy ->t0   1 sp*sy ->t1   2 cr*t0 ->e  3 sr*t1 +e ->w
    //  4 sr*t0 ->e    5 e-cr*t1 ->x 6 cr*sp ->t0 7 t0*cy ->e
    //  8 sr*cp ->t0   9 t0*sy +e ->y 10 cr*cp ->t0 11 t0*sy ->e
    //  12 sr*sp ->t0  13 t0*cy -> z = e - p
    // Hamilton schedule: 16 products, four per component.
    // Matrix schedule: 9 products, squares and cross terms.
    always_comb
    begin
        ma = 16'sd0;
        mb = 16'sd0;
        unique case (state_reg)
            S_EUL:
            begin
                unique case (cnt_reg)
                    5'd0:    begin ma = cp_reg; mb = cy_reg; end
                    5'd1:    begin ma = sp_reg; mb = sy_reg; end
                    5'd2:    begin ma = cr_reg; mb = t0_reg; end
                    5'd3:    begin ma = sr_reg; mb = t1_reg; end
                    5'd4:    begin ma = sr_reg; mb = t0_reg; end
                    5'd5:    begin ma = cr_reg; mb = t1_reg; end
                    5'd6:    begin ma = cr_reg; mb = sp_reg; end
                    5'd7:    begin ma = t0_reg; mb = cy_reg; end
                    5'd8:    begin ma = sr_reg; mb = cp_reg; end
                    5'd9:    begin ma = t0_reg; mb = sy_reg; end
                    5'd10:   begin ma = cr_reg; mb = cp_reg; end
                    5'd11:   begin ma = t0_reg; mb = sy_reg; end
                    5'd12:   begin ma = sr_reg; mb = sp_reg; end
                    default: begin ma = t0_reg; mb = cy_reg; end
                endcase
            end
            S_HAM:
            begin
                unique case (cnt_reg[1:0])
                    2'd0: ma = qx_reg;
                    2'd1: ma = qy_reg;
                    2'd2: ma = qz_reg;
                    default: ma = qw_reg;
                endcase
                // component cnt[3:2]: 0 x, 1 y, 2 z, 3 w
                unique case (cnt_reg[3:0])
                    4'd0:  mb = fw_reg;  4'd1:  mb = fz_reg;
                    4'd2:  mb = fy_reg;  4'd3:  mb = fx_reg;
                    4'd4:  mb = fz_reg;  4'd5:  mb = fw_reg;
                    4'd6:  mb = fx_reg;  4'd7:  mb = fy_reg;
                    4'd8:  mb = fy_reg;  4'd9:  mb = fx_reg;
                    4'd10: mb = fw_reg;  4'd11: mb = fz_reg;
                    4'd12: mb = fx_reg;  4'd13: mb = fy_reg;
                    4'd14: mb = fz_reg;  default: mb = fw_reg;
                endcase
            end
            S_MAT:
            begin
                unique case (cnt_reg)
                    5'd0:    begin ma = qx_reg; mb = qx_reg; end
                    5'd1:    begin ma = qy_reg; mb = qy_reg; end
                    5'd2:    begin ma = qz_reg; mb = qz_reg; end
                    5'd3:    begin ma = qx_reg; mb = qy_reg; end
                    5'd4:    begin ma = qw_reg; mb = qz_reg; end
                    5'd5:    begin ma = qx_reg; mb = qz_reg; end
                    5'd6:    begin ma = qw_reg; mb = qy_reg; end
                    5'd7:    begin ma = qy_reg; mb = qz_reg; end
                    5'd8:    begin ma = qw_reg; mb = qx_reg; end
                    default: begin ma = 16'sd0; mb = 16'sd0; end
                endcase
            end
            default: ;
        endcase
    end

    // Product register for the matrix step
    logic signed [31:0] p_reg;
    // Squares and cross products held for matrix assembly
    logic signed [31:0] xx_reg, yy_reg, zz_reg, a_reg;

    logic signed [35:0] hp;

    assign hp = 36'(prod);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ang_next   = ang_reg;
        row_next   = row_reg;
        cord_start = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cnt_next = 5'd0;
                    row_next = 2'd0;
                    ang_next = 2'd0;
                    if (opcode == OP_EULER)
                        state_next = S_CORD;
                    else
                        state_next = S_HAM;
                end
            end
            S_CORD:
            begin
                if (cnt_reg == 5'd0)
                begin
                    cord_start = 1'b1;
                    cnt_next   = 5'd1;
                end
                else if (cord_done)
                begin
                    cnt_next = 5'd0;
                    if (ang_reg == 2'd2)
                        state_next = S_EUL;
                    else
                        ang_next = ang_reg + 2'd1;
                end
            end
            S_EUL:
            begin
                if (cnt_reg == 5'd13)
                begin
                    cnt_next   = 5'd0;
                    state_next = S_MAT;
                end
                else
                    cnt_next = cnt_reg + 5'd1;
            end
            S_HAM:
            begin
                if (cnt_reg == 5'd15)
                begin
                    cnt_next   = 5'd0;
                    state_next = S_MAT;
                end
                else
                    cnt_next = cnt_reg + 5'd1;
            end
            S_MAT:
            begin
                // products at 0..8, one pipeline register, assembly through 12
                if (cnt_reg == 5'd12)
                begin
                    cnt_next   = 5'd0;
                    state_next = S_OUT;
                end
                else
                    cnt_next = cnt_reg + 5'd1;
            end
            S_OUT:
            begin
                if (out_fire)
                begin
                    if (row_reg == 2'd2)
                        state_next = S_IDLE;
                    else
                        row_next = row_reg + 2'd1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= 5'd0;
            ang_reg   <= 2'd0;
            row_reg   <= 2'd0;
            qw_reg    <= RESET_W;
            qx_reg    <= RESET_X;
            qy_reg    <= RESET_Y;
            qz_reg    <= RESET_Z;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ang_reg   <= ang_next;
            row_reg   <= row_next;
            if (state_reg == S_EUL)
            begin
                unique case (cnt_reg)
                    5'd3:    qw_reg <= sat16(e_reg + 20'(pr));
                    5'd5:    qx_reg <= sat16(e_reg - 20'(pr));
                    5'd9:    qy_reg <= sat16(e_reg + 20'(pr));
                    5'd13:   qz_reg <= sat16(e_reg - 20'(pr));
                    default: ;
                endcase
            end
            else if (state_reg == S_HAM && cnt_reg == 5'd15)
            begin
                // all products used the old state; commit together
                qw_reg <= round_sat(40'(acc_reg + hp));
                qx_reg <= hx_reg;
                qy_reg <= hy_reg;
                qz_reg <= hz_reg;
            end
        end
    end

    // Sign of each Hamilton term (true = subtract)
    logic ham_neg;
    always_comb
    begin
        unique case (cnt_reg[3:0])
            4'd2, 4'd4, 4'd9, 4'd12, 4'd13, 4'd14: ham_neg = 1'b1;
            default:                                ham_neg = 1'b0;
        endcase
    end

    // Payload registers
    logic signed [35:0] ham_term;
    assign ham_term = ham_neg ? -hp : hp;

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ang_r_reg <= roll;
            ang_p_reg <= pitch;
            ang_y_reg <= yaw;
            fw_reg    <= factor_w;
            fx_reg    <= factor_x;
            fy_reg    <= factor_y;
            fz_reg    <= factor_z;
        end
        if (state_reg == S_CORD && cord_done)
        begin
            unique case (ang_reg)
                2'd0:    begin cr_reg <= cord_cos; sr_reg <= cord_sin; end
                2'd1:    begin cp_reg <= cord_cos; sp_reg <= cord_sin; end
                default: begin cy_reg <= cord_cos; sy_reg <= cord_sin; end
            endcase
        end
        if (state_reg == S_EUL)
        begin
            unique case (cnt_reg)
                5'd0, 5'd6, 5'd8, 5'd10, 5'd12: t0_reg <= pr;
                5'd1:                           t1_reg <= pr;
                5'd2, 5'd4, 5'd7, 5'd11:        e_reg  <= 20'(pr);
                default: ;
            endcase
        end
        if (state_reg == S_HAM)
        begin
            if (cnt_reg[1:0] == 2'd0)
                acc_reg <= ham_term;
            else
                acc_reg <= acc_reg + ham_term;
            if (cnt_reg[1:0] == 2'd3)
            begin
                unique case (cnt_reg[3:2])
                    2'd0:    hx_reg <= round_sat(40'(acc_reg + hp));
                    2'd1:    hy_reg <= round_sat(40'(acc_reg + hp));
                    2'd2:    hz_reg <= round_sat(40'(acc_reg + hp));
                    default: ;
                endcase
            end
        end
        if (state_reg == S_MAT)
        begin
            p_reg <= prod;
            // cnt-1 product is in p_reg
            unique case (cnt_reg)
                5'd1:  xx_reg <= p_reg;
                5'd2:  yy_reg <= p_reg;
                5'd3:  zz_reg <= p_reg;
                5'd4:  a_reg  <= p_reg;                 // xy
                5'd5:
                begin                                   // p = wz
                    m_reg[1] <= round_sat(40'(2 * (36'(a_reg) - 36'(p_reg))));
                    m_reg[3] <= round_sat(40'(2 * (36'(a_reg) + 36'(p_reg))));
                end
                5'd6:  a_reg  <= p_reg;                 // xz
                5'd7:
                begin                                   // p = wy
                    m_reg[2] <= round_sat(40'(2 * (36'(a_reg) + 36'(p_reg))));
                    m_reg[6] <= round_sat(40'(2 * (36'(a_reg) - 36'(p_reg))));
                end
                5'd8:  a_reg  <= p_reg;                 // yz
                5'd9:
                begin                                   // p = wx
                    m_reg[5] <= round_sat(40'(2 * (36'(a_reg) - 36'(p_reg))));
                    m_reg[7] <= round_sat(40'(2 * (36'(a_reg) + 36'(p_reg))));
                end
                5'd10: m_reg[0] <= round_sat(
                           40'(ONE_Q28 - 2 * (36'(yy_reg) + 36'(zz_reg))));
                5'd11: m_reg[4] <= round_sat(
                           40'(ONE_Q28 - 2 * (36'(xx_reg) + 36'(zz_reg))));
                5'd12: m_reg[8] <= round_sat(
                           40'(ONE_Q28 - 2 * (36'(xx_reg) + 36'(yy_reg))));
                default: ;
            endcase
        end
    end

    assign quat_w    = qw_reg;
    assign quat_x    = qx_reg;
    assign quat_y    = qy_reg;
    assign quat_z    = qz_reg;
    assign row_index = row_reg;
    assign last_row  = (row_reg == 2'd2);

    always_comb
    begin
        unique case (row_reg)
            2'd0:
            begin
                row_entry_first  = m_reg[0];
                row_entry_second = m_reg[1];
                row_entry_third  = m_reg[2];
            end
            2'd1:
            begin
                row_entry_first  = m_reg[3];
                row_entry_second = m_reg[4];
                row_entry_third  = m_reg[5];
            end
            default:
            begin
                row_entry_first  = m_reg[6];
                row_entry_second = m_reg[7];
                row_entry_third  = m_reg[8];
            end
        endcase
    end

endmodule

`default_nettype wire
